FILE: design/faor_pkg.sv
// faor_pkg: shared types and constants of the room allocator
// field widths, reset value of the room count register, controller command and status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package faor_pkg;

  // field and store widths
  localparam int TIME_W = 32;
  localparam int FREE_W = 40;
  localparam int CNT_W  = 16;
  localparam int ROOM_W = 4;
  localparam int CFG_W  = 5;

  // room count after reset
  localparam logic [CFG_W-1:0] NUM_ROOMS_RST = 5'd16;

  // saturation limits
  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic load;    // capture a new request, reset scan trackers
    logic issue;   // read one room entry at the scan address
    logic update;  // write back chosen room, present result
  } faor_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_last;  // scan address is the last active room
  } faor_sts_t;

endpackage

`default_nettype wire

FILE: design/faor_ctrl.sv
// faor_ctrl: sequencing state machine of the room allocator
// steps idle, scan, drain and update; depends on faor_pkg
`timescale 1ns / 1ps
`default_nettype none

module faor_ctrl
  import faor_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  faor_sts_t      sts,
  output faor_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: design/faor_dpath.sv
// faor_dpath: room stores, scan trackers and result registers of the room allocator
// free-time and use-count memories with per-room valid bits; depends on faor_pkg
`timescale 1ns / 1ps
`default_nettype none

module faor_dpath
  import faor_pkg::*;
#(
  parameter int MAX_ROOMS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  faor_cmd_t              cmd,
  output faor_sts_t              sts,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [TIME_W-1:0] in_start_time,
  input  wire logic [TIME_W-1:0] in_end_time,
  input  wire logic              in_is_last,
  output logic                   out_strobe,
  output logic [ROOM_W-1:0]      out_assigned_room,
  output logic                   out_was_delayed,
  output logic [ROOM_W-1:0]      out_most_used_room,
  output logic                   out_batch_done
);

  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

  // room count register
  logic [CFG_W-1:0] num_rooms_r;
  logic [IDX_W-1:0] last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rooms_r <= NUM_ROOMS_RST;
    end else if (cfg_we) begin
      num_rooms_r <= cfg_wdata;
    end
  end

  // last active room index, count clamped to one and to the built maximum
  always_comb begin
    if (num_rooms_r == '0) begin
      last_idx = '0;
    end else if (32'(num_rooms_r) > 32'(MAX_ROOMS)) begin
      last_idx = IDX_W'(MAX_ROOMS - 1);
    end else begin
      last_idx = IDX_W'(num_rooms_r - 5'd1);
    end
  end

  // captured request
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] dur_r;
  logic [TIME_W-1:0] stop_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_start_time;
      last_r  <= in_is_last;
      if (in_end_time > in_start_time) begin
        dur_r  <= in_end_time - in_start_time;
        stop_r <= in_end_time;
      end else begin
        dur_r  <= '0;
        stop_r <= in_start_time;
      end
    end
  end

  // scan address
  logic [IDX_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + 1'b1;
    end
  end

  assign sts.issue_last = (addr_r == last_idx);

  // valid bits: an entry never written since the last clear reads as zero
  logic [MAX_ROOMS-1:0] valid_r;
  logic [IDX_W-1:0]     sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.update) begin
      if (last_r) begin
        valid_r <= '0;
      end else begin
        valid_r[sel] <= 1'b1;
      end
    end
  end

  // room stores with registered read
  logic [FREE_W-1:0] free_mem [MAX_ROOMS];
  logic [CNT_W-1:0]  cnt_mem  [MAX_ROOMS];
  logic [FREE_W-1:0] free_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [FREE_W-1:0] free_new;
  logic [CNT_W-1:0]  cnt_new;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      free_mem[sel] <= free_new;
    end
    if (cmd.issue) begin
      free_q <= free_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cnt_mem[sel] <= cnt_new;
    end
    if (cmd.issue) begin
      cnt_q <= cnt_mem[addr_r];
    end
  end

  // read pipeline tag
  logic             rd_vld_r;
  logic             rd_ok_r;
  logic [IDX_W-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_idx_r <= addr_r;
      rd_ok_r  <= valid_r[addr_r];
    end
  end

  // scan trackers: first free room, earliest-free room, most used room
  logic [FREE_W-1:0] rd_free;
  logic [CNT_W-1:0]  rd_cnt;
  logic              found_r;
  logic [IDX_W-1:0]  chosen_r;
  logic [CNT_W-1:0]  chosen_cnt_r;
  logic [IDX_W-1:0]  best_r;
  logic [FREE_W-1:0] best_free_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [IDX_W-1:0]  top_r;
  logic [CNT_W-1:0]  top_cnt_r;

  assign rd_free = rd_ok_r ? free_q : '0;
  assign rd_cnt  = rd_ok_r ? cnt_q  : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r   <= 1'b0;
      top_r     <= '0;
      top_cnt_r <= '0;
    end else if (rd_vld_r) begin
      if (!found_r && (rd_free <= {{(FREE_W-TIME_W){1'b0}}, start_r})) begin
        found_r      <= 1'b1;
        chosen_r     <= rd_idx_r;
        chosen_cnt_r <= rd_cnt;
      end
      if ((rd_idx_r == '0) || (rd_free < best_free_r)) begin
        best_r      <= rd_idx_r;
        best_free_r <= rd_free;
        best_cnt_r  <= rd_cnt;
      end
      if (rd_cnt > top_cnt_r) begin
        top_r     <= rd_idx_r;
        top_cnt_r <= rd_cnt;
      end
    end
  end

  // update values for the chosen room
  logic [CNT_W-1:0]  sel_cnt;
  logic [FREE_W:0]   free_sum;
  logic [IDX_W-1:0]  top_new;

  assign sel      = found_r ? chosen_r : best_r;
  assign sel_cnt  = found_r ? chosen_cnt_r : best_cnt_r;
  assign free_sum = {1'b0, best_free_r} + {{(FREE_W+1-TIME_W){1'b0}}, dur_r};

  always_comb begin
    if (found_r) begin
      free_new = {{(FREE_W-TIME_W){1'b0}}, stop_r};
    end else if (free_sum[FREE_W]) begin
      free_new = FREE_MAX;
    end else begin
      free_new = free_sum[FREE_W-1:0];
    end
    cnt_new = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
  end

  // only the chosen room's count moves, so the leader is the old one or the chosen room
  always_comb begin
    if (sel == top_r) begin
      top_new = top_r;
    end else if (cnt_new > top_cnt_r) begin
      top_new = sel;
    end else if ((cnt_new == top_cnt_r) && (sel < top_r)) begin
      top_new = sel;
    end else begin
      top_new = top_r;
    end
  end

  // result registers
  logic              strobe_r;
  logic [ROOM_W-1:0] assigned_r;
  logic              delayed_r;
  logic [ROOM_W-1:0] most_used_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      assigned_r  <= ROOM_W'(sel);
      delayed_r   <= ~found_r;
      most_used_r <= ROOM_W'(top_new);
      done_r      <= last_r;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_assigned_room  = assigned_r;
  assign out_was_delayed    = delayed_r;
  assign out_most_used_room = most_used_r;
  assign out_batch_done     = done_r;

endmodule

`default_nettype wire

FILE: design/first_free_or_earliest_room_allocator_unit.sv
// first_free_or_earliest_room_allocator_unit: top level of the room allocator
// joins faor_ctrl and faor_dpath; depends on faor_pkg
//
// Usage:
//   A request (start time, end time, last flag) is taken at a rising edge with
//   start high and busy low. It goes to the lowest active room free at its start,
//   else to the room that frees earliest (lowest index on a tie), delayed there.
//   Each request gives one result on the out_ ports, marked by out_strobe for
//   exactly one cycle: assigned room, delayed flag, most used room so far and
//   an echo of the last flag. The receiver cannot stall; results are not held.
//   Steps: one room entry is read per cycle from the free-time and use-count
//   memories for each active room, then a drain step and a write-back step;
//   the result register is loaded at write-back. A new request can be taken
//   in the cycle the result is shown, not before.
//   cfg_we with cfg_wdata writes the room count (0 acts as 1, above MAX_ROOMS
//   acts as MAX_ROOMS); write it only while busy is low.
//   Reset sets the room count to 16 and clears every room's free time and use
//   count at once; a request marked last clears them again after its result.
`timescale 1ns / 1ps
`default_nettype none

module first_free_or_earliest_room_allocator_unit
  import faor_pkg::*;
#(
  parameter int MAX_ROOMS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [TIME_W-1:0] in_start_time,
  input  wire logic [TIME_W-1:0] in_end_time,
  input  wire logic              in_is_last,
  output logic                   out_strobe,
  output logic [ROOM_W-1:0]      out_assigned_room,
  output logic                   out_was_delayed,
  output logic [ROOM_W-1:0]      out_most_used_room,
  output logic                   out_batch_done
);

  faor_cmd_t cmd;
  faor_sts_t sts;

  // sequencer
  faor_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // stores and result path
  faor_dpath #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_start_time      (in_start_time),
    .in_end_time        (in_end_time),
    .in_is_last         (in_is_last),
    .out_strobe         (out_strobe),
    .out_assigned_room  (out_assigned_room),
    .out_was_delayed    (out_was_delayed),
    .out_most_used_room (out_most_used_room),
    .out_batch_done     (out_batch_done)
  );

endmodule

`default_nettype wire
